// ----- hdl/percent_url_decoder_unit_defines.svh -----
// assertion macros for the percent url decoder checker
// relies on a clock named aclk and an active-low reset named aresetn in scope
`ifndef PERCENT_URL_DECODER_UNIT_DEFINES_SVH
`define PERCENT_URL_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define PUD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pud check failed");

// next-cycle implication, disabled during reset
`define PUD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pud check failed");

`endif

// ----- hdl/pud_pkg.sv -----
// shared types and constants for the percent url decoder
// no dependencies
package pud_pkg;

    localparam int CHAR_W      = 8;
    localparam int LEN_W       = 12;
    localparam int MAX_CAND    = 3;
    localparam int CAND_CNT_W  = 2;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [LEN_W-1:0]  LIMIT_RESET = 12'd255;

    localparam logic [CHAR_W-1:0] CH_PERCENT = 8'h25;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

    // escape sequence progress
    typedef enum logic [1:0] {
        PEND_NONE,
        PEND_PCT,
        PEND_DIGIT
    } pud_pend_t;

    // one classified input: up to three candidate bytes and the end mark
    typedef struct packed {
        logic                               last;
        logic [CAND_CNT_W-1:0]              num;
        logic [MAX_CAND-1:0][CHAR_W-1:0]    data;
    } pud_entry_t;

endpackage

// ----- hdl/percent_url_decoder_unit.sv -----
// top level of the streaming url percent decoder
// depends on pud_pkg, pud_front, pud_queue, pud_back
//
// Input stream: one encoded character per transfer in s_axis_tdata, s_axis_tlast on the
// final character of a string. Output stream: one decoded byte per transfer,
// m_axis_tuser high when the byte is real; the final transfer of a string carries
// m_axis_tlast and the decoded length. A string that keeps no byte ends with a single
// transfer with m_axis_tuser low.
// A character that yields a byte passes through its queue entry (written at the transfer
// edge) and then the output register before it shows on m_axis_tvalid.
// Throughput: one character per cycle while each yields at most one byte. A character
// that flushes a broken escape yields two or three bytes and holds the back end while it
// emits each; the four-entry queue absorbs these, so input stalls only when it fills.
// out_limit is written by cfg_wr_en/cfg_wr_data; the user must write it only while the
// block is idle, which the block does not enforce; reset sets 255. Reset clears the escape
// state, the byte count, the queue and the output valid bit. When m_axis_tready is low the
// output register holds and the queue fills, then s_axis_tready drops.
module percent_url_decoder_unit import pud_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [LEN_W-1:0]    cfg_wr_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // [7:0] in_char
    input  logic                s_axis_tlast,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [23:0]         m_axis_tdata,   // [7:0] out_byte, [19:8] out_length, zeros
    output logic                m_axis_tuser,   // [0] out_valid
    output logic                m_axis_tlast
);

    logic [LEN_W-1:0]   limit_reg;
    logic               push, q_full, pop, head_valid;
    pud_entry_t         push_entry, head_entry;
    logic [CHAR_W-1:0]  out_byte;
    logic [LEN_W-1:0]   out_length;

    // limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    assign s_axis_tready = !q_full;

    pud_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_axis_tvalid),
        .s_tready   (s_axis_tready),
        .s_char     (s_axis_tdata),
        .s_last     (s_axis_tlast),
        .push       (push),
        .push_entry (push_entry)
    );

    pud_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    pud_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .out_limit    (limit_reg),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .pop          (pop),
        .m_tvalid     (m_axis_tvalid),
        .m_tready     (m_axis_tready),
        .m_byte       (out_byte),
        .m_byte_valid (m_axis_tuser),
        .m_last       (m_axis_tlast),
        .m_length     (out_length)
    );

    assign m_axis_tdata = {4'd0, out_length, out_byte};

endmodule

// ----- hdl/pud_front.sv -----
// front end: accepts characters, tracks escape sequences, emits candidate byte lists
// depends on pud_pkg
module pud_front import pud_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [CHAR_W-1:0]   s_char,
    input  logic                s_last,
    output logic                push,
    output pud_entry_t          push_entry
);

    pud_pend_t          pend_reg, pend_next;
    logic [CHAR_W-1:0]  held_reg, held_next;

    // hex digit decode: {is_hex, nibble}
    function automatic logic [4:0] hex_decode(input logic [CHAR_W-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= PEND_NONE;
            held_reg <= '0;
        end else begin
            pend_reg <= pend_next;
            held_reg <= held_next;
        end
    end

    // classify the character and build the candidate list
    always_comb begin
        logic [4:0]             cur_hex;
        logic [4:0]             held_hex;
        logic                   do_fresh;
        logic [CAND_CNT_W-1:0]  cnt;
        logic [MAX_CAND-1:0][CHAR_W-1:0] data;

        cur_hex   = hex_decode(s_char);
        held_hex  = hex_decode(held_reg);
        do_fresh  = 1'b0;
        cnt       = '0;
        data      = '0;
        pend_next = pend_reg;
        held_next = held_reg;

        if (s_tvalid && s_tready) begin
            unique case (pend_reg)
                PEND_PCT: begin
                    if (cur_hex[4]) begin
                        held_next = s_char;
                        pend_next = PEND_DIGIT;
                    end else begin
                        pend_next = PEND_NONE;
                        data[cnt] = CH_PERCENT;
                        cnt       = cnt + 2'd1;
                        do_fresh  = 1'b1;
                    end
                end
                PEND_DIGIT: begin
                    pend_next = PEND_NONE;
                    held_next = '0;
                    if (cur_hex[4]) begin
                        data[cnt] = {held_hex[3:0], cur_hex[3:0]};
                        cnt       = cnt + 2'd1;
                    end else begin
                        data[cnt] = CH_PERCENT;
                        cnt       = cnt + 2'd1;
                        data[cnt] = held_reg;
                        cnt       = cnt + 2'd1;
                        do_fresh  = 1'b1;
                    end
                end
                default: begin
                    pend_next = PEND_NONE;
                    do_fresh  = 1'b1;
                end
            endcase

            // character taken on its own
            if (do_fresh) begin
                if (s_char == CH_PERCENT) begin
                    pend_next = PEND_PCT;
                end else begin
                    data[cnt] = (s_char == CH_PLUS) ? CH_SPACE : s_char;
                    cnt       = cnt + 2'd1;
                end
            end

            // end of string flushes any open escape
            if (s_last) begin
                if (pend_next == PEND_PCT) begin
                    data[cnt] = CH_PERCENT;
                    cnt       = cnt + 2'd1;
                end else if (pend_next == PEND_DIGIT) begin
                    data[cnt] = CH_PERCENT;
                    cnt       = cnt + 2'd1;
                    data[cnt] = held_next;
                    cnt       = cnt + 2'd1;
                end
                pend_next = PEND_NONE;
                held_next = '0;
            end
        end

        push            = s_tvalid && s_tready && ((cnt != '0) || s_last);
        push_entry.last = s_last;
        push_entry.num  = cnt;
        push_entry.data = data;
    end

endmodule

// ----- hdl/pud_queue.sv -----
// small register queue between the front and back ends
// depends on pud_pkg
module pud_queue import pud_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  pud_entry_t  push_entry,
    output logic        full,
    input  logic        pop,
    output logic        head_valid,
    output pud_entry_t  head_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pud_entry_t         slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slots[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- hdl/pud_back.sv -----
// back end: walks candidate lists, applies the length limit, drives the output register
// depends on pud_pkg
module pud_back import pud_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [LEN_W-1:0]    out_limit,
    input  logic                head_valid,
    input  pud_entry_t          head_entry,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [CHAR_W-1:0]   m_byte,
    output logic                m_byte_valid,
    output logic                m_last,
    output logic [LEN_W-1:0]    m_length
);

    logic [CAND_CNT_W-1:0]  idx_reg, idx_next;
    logic [LEN_W-1:0]       count_reg, count_next;
    logic                   m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]      m_byte_reg;
    logic                   m_bvalid_reg;
    logic                   m_last_reg;
    logic [LEN_W-1:0]       m_len_reg;

    logic                   out_free, emit, emit_bvalid, emit_last;
    logic [CHAR_W-1:0]      emit_byte;
    logic [LEN_W-1:0]       emit_len, next_len;
    logic                   keep, is_tail;

    assign out_free = !m_valid_reg || m_tready;
    assign next_len = count_reg + 1'b1;
    assign keep     = (idx_reg < head_entry.num) && (count_reg < out_limit);
    assign is_tail  = (idx_reg == head_entry.num - 1'b1);

    // one candidate per cycle into the output register, while it is free to load
    always_comb begin
        pop          = 1'b0;
        emit         = 1'b0;
        emit_bvalid  = 1'b0;
        emit_last    = 1'b0;
        emit_byte    = '0;
        emit_len     = count_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        if (head_valid && out_free) begin
            if (keep) begin
                emit        = 1'b1;
                emit_bvalid = 1'b1;
                emit_byte   = head_entry.data[idx_reg];
                emit_len    = next_len;
                // later candidates would be dropped once the limit is hit
                emit_last   = head_entry.last && (is_tail || (next_len >= out_limit));
                count_next  = emit_last ? '0 : next_len;
                if (is_tail || emit_last) begin
                    pop      = 1'b1;
                    idx_next = '0;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end else begin
                // nothing kept from here on; close the string if needed
                pop      = 1'b1;
                idx_next = '0;
                if (head_entry.last) begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    count_next = '0;
                end
            end
        end
        m_valid_next = out_free ? emit : m_valid_reg;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            idx_reg     <= idx_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (out_free && emit) begin
            m_byte_reg   <= emit_byte;
            m_bvalid_reg <= emit_bvalid;
            m_last_reg   <= emit_last;
            m_len_reg    <= emit_len;
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign m_byte       = m_byte_reg;
    assign m_byte_valid = m_bvalid_reg;
    assign m_last       = m_last_reg;
    assign m_length     = m_len_reg;

endmodule

// ----- hdl/pud_checker.sv -----
// port-level checker for the percent url decoder, bound to the top level
// depends on percent_url_decoder_unit_defines.svh
`include "percent_url_decoder_unit_defines.svh"

module pud_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tlast
);

    // a stalled result holds its payload
    `PUD_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // an empty result only ever closes a string, with a zero byte
    `PUD_ASSERT_NOW(a_empty_final, m_axis_tvalid && !m_axis_tuser, m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))

    // a kept byte always counts at least itself
    `PUD_ASSERT_NOW(a_len_nonzero, m_axis_tvalid && m_axis_tuser, m_axis_tdata[19:8] != 12'd0)

    // pad bits stay zero
    `PUD_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[23:20] == 4'd0)

endmodule

bind percent_url_decoder_unit pud_checker u_pud_checker (.*);
